// ===== rtl/swc_pkg.sv =====
// Package for the square wave channel: types, constants and tables.
// No dependencies.
package swc_pkg;

   localparam int SEQ_STEPS = 8;
   localparam int SEQ_W = $clog2(SEQ_STEPS);

   typedef enum logic [2:0] {
      ACT_WRITE   = 3'd0,
      ACT_ENABLE  = 3'd1,
      ACT_DISABLE = 3'd2,
      ACT_ENV     = 3'd3,
      ACT_SWEEP   = 3'd4,
      ACT_LENGTH  = 3'd5,
      ACT_SAMPLE  = 3'd6,
      ACT_NONE    = 3'd7
   } action_type;

   localparam logic [1:0] REG_CTRL   = 2'd0;
   localparam logic [1:0] REG_SWEEP  = 2'd1;
   localparam logic [1:0] REG_PLO    = 2'd2;
   localparam logic [1:0] REG_PHI    = 2'd3;

   localparam logic CSR_NS  = 1'b0;
   localparam logic CSR_CH1 = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV,
      ST_SEQ,
      ST_SWEEP,
      ST_OUT
   } state_type;

   // controller -> datapath commands
   typedef struct packed {
      logic load;       // capture item
      logic exec;       // run the item's action
      logic div_start;  // start overflow divide
      logic div_step;   // one quotient bit
      logic seq_upd;    // apply quotient
      logic sweep_upd;  // recompute sweep target
      logic out_load;   // load result register
   } cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic       need_div;
      logic       div_done;
      action_type act;
   } sts_type;

   function automatic logic [7:0] duty_bits(input logic [1:0] d);
      logic [7:0] r;
      unique case (d)
         2'd0: r = 8'h08;
         2'd1: r = 8'h0C;
         2'd2: r = 8'h0F;
         default: r = 8'h30;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] length_load(input logic [4:0] i);
      logic [7:0] r;
      unique case (i)
         5'd0: r = 8'h0A;  5'd1: r = 8'hFE;  5'd2: r = 8'h14;  5'd3: r = 8'h02;
         5'd4: r = 8'h28;  5'd5: r = 8'h04;  5'd6: r = 8'h50;  5'd7: r = 8'h06;
         5'd8: r = 8'hA0;  5'd9: r = 8'h08;  5'd10: r = 8'h3C; 5'd11: r = 8'h0A;
         5'd12: r = 8'h0E; 5'd13: r = 8'h0C; 5'd14: r = 8'h1A; 5'd15: r = 8'h0E;
         5'd16: r = 8'h0C; 5'd17: r = 8'h10; 5'd18: r = 8'h18; 5'd19: r = 8'h12;
         5'd20: r = 8'h30; 5'd21: r = 8'h14; 5'd22: r = 8'h60; 5'd23: r = 8'h16;
         5'd24: r = 8'hC0; 5'd25: r = 8'h18; 5'd26: r = 8'h48; 5'd27: r = 8'h1A;
         5'd28: r = 8'h10; 5'd29: r = 8'h1C; 5'd30: r = 8'h20; default: r = 8'h1E;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/swc_ctrl.sv =====
// Sequencer for the square wave channel: steps each item through its phases.
// Depends on swc_pkg.
module swc_ctrl import swc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_fire,
   input  logic    rsp_fire,
   input  logic    rsp_full,
   input  sts_type sts,
   output logic    req_tready,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_fire) state_in = ST_EXEC;
         ST_EXEC: begin
            if (sts.act == ACT_SAMPLE && sts.need_div) state_in = ST_DIV;
            else if (sts.act == ACT_WRITE || sts.act == ACT_SWEEP) state_in = ST_SWEEP;
            else state_in = ST_OUT;
         end
         ST_DIV:   if (sts.div_done) state_in = ST_SEQ;
         ST_SEQ:   state_in = ST_OUT;
         ST_SWEEP: state_in = ST_OUT;
         ST_OUT:   if (!rsp_full || rsp_fire) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs; payload register tracks the bus while idle
   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE:  begin req_tready = 1'b1; cmd.load = 1'b1; end
         ST_EXEC:  begin cmd.exec = 1'b1; cmd.div_start = 1'b1; end
         ST_DIV:   cmd.div_step = 1'b1;
         ST_SEQ:   cmd.seq_upd = 1'b1;
         ST_SWEEP: cmd.sweep_upd = 1'b1;
         ST_OUT:   cmd.out_load = !rsp_full || rsp_fire;
         default:  cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

endmodule

// ===== rtl/swc_datapath.sv =====
// Datapath of the square wave channel: channel state, divider, result register.
// Depends on swc_pkg.
module swc_datapath import swc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic [19:0] ns_per_sample,
   input  logic        is_channel_one,
   input  logic [2:0]  req_action,
   input  logic [1:0]  req_reg_index,
   input  logic [7:0]  req_write_data,
   input  cmd_type     cmd,
   output sts_type     sts,
   output logic [3:0]  out_sample,
   output logic        out_length_nonzero
);

   logic [2:0]  act_ff;
   logic [1:0]  idx_ff;
   logic [7:0]  data_ff;
   logic [7:0]  control_ff, sweep_ff;
   logic [10:0] period_ff;
   logic [15:0] target_ff;
   logic        target_ok_ff, reload_ff, env_start_ff, len_en_ff;
   logic [2:0]  sdiv_ff;
   logic [3:0]  env_level_ff, env_div_ff, amp_ff;
   logic [SEQ_W-1:0] step_ff;
   logic [7:0]  len_ff;
   logic [31:0] acc_ff;
   logic [3:0]  smp_ff;
   // divider: remainder, quotient bits, bit counter
   logic [31:0] dnum_ff, quo_ff;
   logic [32:0] rem_ff;
   logic [5:0]  dcnt_ff;

   action_type act;
   assign act = action_type'(act_ff);

   // accumulator after the increment
   logic [31:0] acc_sum;
   assign acc_sum = acc_ff + {22'd0, ns_per_sample[19:10]};
   assign sts.act = act;
   assign sts.need_div = (period_ff != 11'd0) && (acc_sum > {21'd0, period_ff});
   assign sts.div_done = (dcnt_ff == 6'd1);

   // envelope next values
   logic [3:0] env_div_dec;
   assign env_div_dec = (env_div_ff != 4'd0) ? env_div_ff - 4'd1 : env_div_ff;

   // sweep next values
   logic [2:0] sper;
   logic [2:0] sdiv_base, sdiv_dec;
   assign sper = sweep_ff[6:4];
   assign sdiv_base = reload_ff ? sper : sdiv_ff;
   assign sdiv_dec = (sdiv_base != 3'd0) ? sdiv_base - 3'd1 : sdiv_base;

   // sweep target from current period
   logic [15:0] delta, tgt;
   always_comb begin
      delta = {5'd0, period_ff} >> sweep_ff[2:0];
      if (sweep_ff[3]) delta = is_channel_one ? ~delta : (16'd0 - delta);
      tgt = {5'd0, period_ff} + delta;
   end

   // quotient step: bit-serial restoring divide of (acc-1) by period
   logic [32:0] rem_sh;
   logic        rem_ge;
   assign rem_sh = {rem_ff[31:0], dnum_ff[31]};
   assign rem_ge = rem_sh >= {22'd0, period_ff};

   logic [31:0] prod;
   assign prod = quo_ff * {21'd0, period_ff};

   logic [7:0]       duty;
   logic             bit_v;
   assign duty = duty_bits(control_ff[7:6]);

   always_comb begin
      bit_v = duty[step_ff];
      if (len_en_ff && len_ff == 8'd0) bit_v = 1'b0;
   end

   // payload capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff <= req_action;
         idx_ff <= req_reg_index;
         data_ff <= req_write_data;
      end
   end

   // channel state
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0; target_ok_ff <= 1'b0; reload_ff <= 1'b0;
         sdiv_ff <= '0; env_start_ff <= 1'b0; env_level_ff <= '0;
         env_div_ff <= '0; amp_ff <= '0; step_ff <= '0; len_ff <= '0;
         len_en_ff <= 1'b0; acc_ff <= '0; dcnt_ff <= '0;
         period_ff <= '0; control_ff <= '0; sweep_ff <= '0;
      end else begin
         if (cmd.exec) begin
            unique case (act)
               ACT_WRITE: begin
                  unique case (idx_ff)
                     REG_CTRL: begin
                        control_ff <= data_ff;
                        amp_ff <= data_ff[4] ? data_ff[3:0] : env_level_ff;
                     end
                     REG_SWEEP: begin sweep_ff <= data_ff; reload_ff <= 1'b1; end
                     REG_PLO:   period_ff[7:0] <= data_ff;
                     default: begin
                        period_ff[10:8] <= data_ff[2:0];
                        if (len_en_ff) len_ff <= length_load(data_ff[7:3]);
                        env_start_ff <= 1'b1;
                     end
                  endcase
               end
               ACT_ENABLE:  len_en_ff <= 1'b1;
               ACT_DISABLE: begin len_en_ff <= 1'b0; len_ff <= '0; end
               ACT_ENV: begin
                  if (env_start_ff) begin
                     env_start_ff <= 1'b0;
                     env_level_ff <= 4'd15;
                     env_div_ff <= control_ff[3:0];
                     if (!control_ff[4]) amp_ff <= 4'd15;
                  end else if (env_div_dec == 4'd0) begin
                     if (env_level_ff == 4'd0) begin
                        if (control_ff[5]) begin
                           env_level_ff <= 4'd15;
                           if (!control_ff[4]) amp_ff <= 4'd15;
                        end else if (!control_ff[4]) amp_ff <= 4'd0;
                     end else begin
                        env_level_ff <= env_level_ff - 4'd1;
                        if (!control_ff[4]) amp_ff <= env_level_ff - 4'd1;
                     end
                     env_div_ff <= control_ff[3:0];
                  end else env_div_ff <= env_div_dec;
               end
               ACT_SWEEP: begin
                  reload_ff <= 1'b0;
                  if (sdiv_dec == 3'd0) begin
                     if (sweep_ff[7] && sweep_ff[2:0] != 3'd0 && target_ok_ff)
                        period_ff <= target_ff[10:0];
                     sdiv_ff <= sper;
                  end else sdiv_ff <= sdiv_dec;
               end
               ACT_LENGTH: if (!control_ff[5] && len_ff != 8'd0) len_ff <= len_ff - 8'd1;
               ACT_SAMPLE: acc_ff <= acc_sum;
               default: ;
            endcase
         end
         if (cmd.div_start) begin
            dnum_ff <= acc_sum - 32'd1;
            rem_ff <= '0;
            quo_ff <= '0;
            dcnt_ff <= 6'd32;
         end
         if (cmd.div_step) begin
            dnum_ff <= {dnum_ff[30:0], 1'b0};
            rem_ff <= rem_ge ? rem_sh - {22'd0, period_ff} : rem_sh;
            quo_ff <= {quo_ff[30:0], rem_ge};
            dcnt_ff <= dcnt_ff - 6'd1;
         end
         if (cmd.seq_upd) begin
            acc_ff <= acc_ff - prod;
            step_ff <= step_ff + quo_ff[SEQ_W-1:0];
         end
         // control writes leave the sweep target as it was
         if (cmd.sweep_upd && !(act == ACT_WRITE && idx_ff == REG_CTRL)) begin
            target_ff <= tgt;
            target_ok_ff <= (period_ff > 11'd7) && (sweep_ff[3] || tgt < 16'h0800);
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_load)
         smp_ff <= (act == ACT_SAMPLE && bit_v) ? amp_ff : 4'd0;
   end

   assign out_sample = smp_ff;
   assign out_length_nonzero = (len_ff != 8'd0);

endmodule

// ===== rtl/square_wave_channel_core.sv =====
// Top level of the square wave channel: controller, datapath, config, output.
// Depends on swc_pkg, swc_ctrl, swc_datapath.
// Phases: accept, EXEC, then SWEEP for register writes and sweep ticks, or DIV
// (bit-serial divide) and SEQ for a sample whose accumulator passes the period, then OUT.
// One item at a time; next item taken after result load.
// Reset: synchronous active high; config returns to its defaults.
module square_wave_channel_core import swc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata, // action[2:0], reg_index[4:3], write_data[12:5]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata, // sample[3:0], length_nonzero[4]
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [19:0] csr_wdata
);

   logic [19:0] ns_ff;
   logic        ch1_ff, valid_ff, lnz_ff;
   logic [3:0]  smp;
   logic        lnz;
   cmd_type     cmd;
   sts_type     sts;
   logic        req_fire, rsp_fire;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ns_ff <= 20'd22676;
         ch1_ff <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_NS:  ns_ff <= csr_wdata;
            default: ch1_ff <= csr_wdata[0];
         endcase
      end
   end

   swc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_fire(req_fire), .rsp_fire(rsp_fire),
      .rsp_full(valid_ff), .sts(sts), .req_tready(req_tready), .cmd(cmd)
   );

   swc_datapath u_dp (
      .clock(clock), .reset(reset), .ns_per_sample(ns_ff), .is_channel_one(ch1_ff),
      .req_action(req_tdata[2:0]), .req_reg_index(req_tdata[4:3]),
      .req_write_data(req_tdata[12:5]), .cmd(cmd), .sts(sts),
      .out_sample(smp), .out_length_nonzero(lnz)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (cmd.out_load) valid_ff <= 1'b1;
      else if (rsp_fire) valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) lnz_ff <= lnz;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = {3'd0, lnz_ff, smp};

endmodule

// ===== rtl/swc_checker.sv =====
// Port-level checks for the square wave channel core, bound to the top level.
// Depends on square_wave_channel_core ports only.
module swc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // one item in flight: an accepted item blocks intake next cycle
   a_one: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("intake not closed after item");

   // result held while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // padding bits are zero
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:5] == 3'd0)
      else $error("padding nonzero");

endmodule

bind square_wave_channel_core swc_checker u_chk (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);

// ===== tb/square_wave_channel_core_test.sv =====
// Self-checking testbench for square_wave_channel_core: drives channel actions
// over the request stream and compares every response with a built-in predictor.
// Depends on swc_pkg and the square_wave_channel_core RTL.
`timescale 1ns / 1ps

module square_wave_channel_core_test;
   import swc_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [19:0] csr_wdata = '0;

   square_wave_channel_core u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   // channel model state
   logic [19:0] m_ns;
   logic        m_ch1;
   logic [7:0]  m_ctrl, m_swp;
   logic [15:0] m_tmr_per, m_target;
   logic        m_target_ok, m_reload, m_env_start, m_len_en;
   logic [2:0]  m_sdiv, m_step;
   logic [3:0]  m_env_lvl, m_env_div, m_amp;
   logic [7:0]  m_len;
   logic [31:0] m_acc;

   logic [7:0] duty_pattern [4] = '{8'h08, 8'h0C, 8'h0F, 8'h30};
   logic [7:0] length_reload [32] = '{
      8'h0A, 8'hFE, 8'h14, 8'h02, 8'h28, 8'h04, 8'h50, 8'h06,
      8'hA0, 8'h08, 8'h3C, 8'h0A, 8'h0E, 8'h0C, 8'h1A, 8'h0E,
      8'h0C, 8'h10, 8'h18, 8'h12, 8'h30, 8'h14, 8'h60, 8'h16,
      8'hC0, 8'h18, 8'h48, 8'h1A, 8'h10, 8'h1C, 8'h20, 8'h1E};

   logic [15:0] pending_items [$];
   logic [4:0]  expected_out [$];   // {length_nonzero, sample}
   int          errors = 0;
   int          cycles = 0;
   int          samples_seen = 0;
   int          results_seen = 0;
   logic        no_idle = 1'b0;
   logic        hold_rsp = 1'b0;
   int          send_gap = 0;
   int          rsp_wait = 0;

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
   endtask

   task automatic model_reset();
      m_ns = 20'd22676; m_ch1 = 1'b1;
      m_ctrl = '0; m_swp = '0; m_tmr_per = '0; m_target = '0;
      m_target_ok = 0; m_reload = 0; m_env_start = 0; m_len_en = 0;
      m_sdiv = '0; m_step = '0; m_env_lvl = '0; m_env_div = '0; m_amp = '0;
      m_len = '0; m_acc = '0;
   endtask

   task automatic update_sweep_target();
      logic [15:0] delta;
      logic        neg;
      delta = m_tmr_per >> m_swp[2:0];
      neg = m_swp[3];
      if (neg) delta = m_ch1 ? ~delta : 16'h0 - delta;
      m_target = m_tmr_per + delta;
      m_target_ok = (m_tmr_per > 16'd7) && (neg || m_target < 16'h0800);
   endtask

   // next level of the channel for one sample request
   task automatic step_sequencer(output logic [3:0] level);
      logic [31:0] n;
      logic        b;
      n = 0;
      m_acc = m_acc + {12'd0, m_ns} / 32'd1024;
      if (m_tmr_per != 0 && m_acc > {16'd0, m_tmr_per}) begin
         n = (m_acc - 32'd1) / {16'd0, m_tmr_per};
         m_acc = m_acc - n * {16'd0, m_tmr_per};
      end
      m_step = m_step + n[2:0];
      b = duty_pattern[m_ctrl[7:6]][m_step];
      if (m_len_en && m_len == 0) b = 1'b0;
      level = b ? m_amp : 4'd0;
   endtask

   // apply one accepted item to the model and queue its response
   task automatic predict_response(input logic [15:0] w);
      action_type  act;
      logic [1:0]  idx;
      logic [7:0]  v;
      logic [3:0]  s;
      act = action_type'(w[2:0]);
      idx = w[4:3];
      v = w[12:5];
      s = 4'd0;
      case (act)
         ACT_WRITE: begin
            case (idx)
               REG_CTRL: begin
                  m_ctrl = v;
                  m_amp = v[4] ? v[3:0] : m_env_lvl;
               end
               REG_SWEEP: begin
                  m_swp = v; m_reload = 1'b1; update_sweep_target();
               end
               REG_PLO: begin
                  m_tmr_per = {m_tmr_per[15:8] & 8'h07, v}; update_sweep_target();
               end
               default: begin
                  m_tmr_per = {5'd0, v[2:0], m_tmr_per[7:0]};
                  if (m_len_en) m_len = length_reload[v[7:3]];
                  m_env_start = 1'b1;
                  update_sweep_target();
               end
            endcase
         end
         ACT_ENABLE: m_len_en = 1'b1;
         ACT_DISABLE: begin
            m_len_en = 1'b0; m_len = '0;
         end
         ACT_ENV: begin
            if (m_env_start) begin
               m_env_start = 1'b0; m_env_lvl = 4'd15; m_env_div = m_ctrl[3:0];
               if (!m_ctrl[4]) m_amp = m_env_lvl;
            end else begin
               if (m_env_div != 0) m_env_div--;
               if (m_env_div == 0) begin
                  if (m_env_lvl == 0) begin
                     if (m_ctrl[5]) m_env_lvl = 4'd15;
                  end else m_env_lvl--;
                  if (!m_ctrl[4]) m_amp = m_env_lvl;
                  m_env_div = m_ctrl[3:0];
               end
            end
         end
         ACT_SWEEP: begin
            if (m_reload) begin
               m_sdiv = m_swp[6:4]; m_reload = 1'b0;
            end
            if (m_sdiv != 0) m_sdiv--;
            if (m_sdiv == 0) begin
               if (m_swp[7] && m_swp[2:0] != 0 && m_target_ok)
                  m_tmr_per = m_target & 16'h07FF;
               m_sdiv = m_swp[6:4];
            end
            update_sweep_target();
         end
         ACT_LENGTH: if (!m_ctrl[5] && m_len != 0) m_len--;
         ACT_SAMPLE: begin
            step_sequencer(s);
            samples_seen++;
         end
         default: ;
      endcase
      expected_out.push_back({m_len != 0, s});
   endtask

   // request driver: one item per free slot, random gap after each item
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) predict_response(req_tdata);
         if (!req_tvalid || req_tready) begin
            if (send_gap != 0) begin
               send_gap <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_items.size() != 0) begin
               req_tdata <= pending_items.pop_front();
               req_tvalid <= 1'b1;
               send_gap <= no_idle ? 0 : $urandom_range(0, 10);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response sink: random stall after each item, or a long hold-off
   always @(posedge clock) begin
      int k;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_rsp) begin
         rsp_tready <= 1'b0;
      end else if (rsp_tvalid && rsp_tready) begin
         k = no_idle ? 0 : $urandom_range(0, 10);
         rsp_wait <= k;
         rsp_tready <= (k == 0);
      end else if (rsp_wait != 0) begin
         rsp_wait <= rsp_wait - 1;
         rsp_tready <= (rsp_wait == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // response checker
   always @(posedge clock) begin
      logic [4:0] e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_out.size() == 0) begin
            report_mismatch($sformatf("unexpected item %h", rsp_tdata));
         end else begin
            e = expected_out.pop_front();
            if (rsp_tdata[3:0] !== e[3:0])
               report_mismatch($sformatf("sample %h, want %h", rsp_tdata[3:0], e[3:0]));
            if (rsp_tdata[4] !== e[4])
               report_mismatch($sformatf("length_nonzero %b, want %b", rsp_tdata[4], e[4]));
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic logic [15:0] pack_item(action_type a, logic [1:0] idx, logic [7:0] v);
      return {3'd0, v, idx, a};
   endfunction

   task automatic send_item(input action_type a, input logic [1:0] idx, input logic [7:0] v);
      pending_items.push_back(pack_item(a, idx, v));
      while (pending_items.size() != 0) @(posedge clock);
   endtask

   task automatic wait_drained();
      while (pending_items.size() != 0 || expected_out.size() != 0 || req_tvalid)
         @(posedge clock);
   endtask

   // config write, only while idle
   task automatic write_csr(input logic idx, input logic [19:0] v);
      wait_drained();
      repeat (40) @(posedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_NS) m_ns = v; else m_ch1 = v[0];
   endtask

   function automatic logic [15:0] random_item();
      int          r;
      logic [1:0]  idx;
      logic [7:0]  v;
      r = $urandom_range(0, 99);
      idx = 2'($urandom_range(0, 3));
      v = 8'($urandom_range(0, 255));
      if (r < 45) return pack_item(ACT_SAMPLE, 2'($urandom_range(0, 3)), v);
      if (r < 70) begin
         // mostly short periods so the sequencer moves
         if (idx == REG_PHI && $urandom_range(0, 3) != 0) v[2:0] = 3'd0;
         if (idx == REG_PLO && $urandom_range(0, 3) != 0) v = 8'($urandom_range(0, 40));
         return pack_item(ACT_WRITE, idx, v);
      end
      if (r < 78) return pack_item(ACT_ENV, idx, v);
      if (r < 85) return pack_item(ACT_SWEEP, idx, v);
      if (r < 92) return pack_item(ACT_LENGTH, idx, v);
      if (r < 96) return pack_item(ACT_ENABLE, idx, v);
      if (r < 98) return pack_item(ACT_DISABLE, idx, v);
      return pack_item(ACT_NONE, idx, v);
   endfunction

   task automatic test_directed();
      send_item(ACT_WRITE, REG_CTRL, 8'h9F);
      send_item(ACT_WRITE, REG_SWEEP, 8'h00);
      send_item(ACT_WRITE, REG_PLO, 8'h10);
      send_item(ACT_WRITE, REG_PHI, 8'hF8);
      send_item(ACT_ENABLE, 2'd0, 8'h00);
      send_item(ACT_WRITE, REG_PHI, 8'h08);   // length load while enabled
      send_item(ACT_SAMPLE, 2'd0, 8'h00);
      send_item(ACT_SAMPLE, 2'd3, 8'hFF);
      send_item(ACT_ENV, 2'd0, 8'h00);
      send_item(ACT_WRITE, REG_CTRL, 8'h41);  // envelope mode, fast decay
      send_item(ACT_ENV, 2'd0, 8'h00);
      send_item(ACT_ENV, 2'd0, 8'h00);
      send_item(ACT_WRITE, REG_SWEEP, 8'hFF); // negate, max shift
      send_item(ACT_SWEEP, 2'd0, 8'h00);
      send_item(ACT_WRITE, REG_SWEEP, 8'h91);
      send_item(ACT_SWEEP, 2'd0, 8'h00);
      send_item(ACT_LENGTH, 2'd0, 8'h00);
      send_item(ACT_NONE, 2'd3, 8'hFF);       // unused action
      // zero period: accumulator grows, sequencer holds
      send_item(ACT_WRITE, REG_PLO, 8'h00);
      send_item(ACT_WRITE, REG_PHI, 8'h00);
      send_item(ACT_SAMPLE, 2'd0, 8'h00);
      send_item(ACT_SAMPLE, 2'd0, 8'h00);
      send_item(ACT_DISABLE, 2'd0, 8'h00);
      send_item(ACT_WRITE, REG_PHI, 8'hFF);
      send_item(ACT_SAMPLE, 2'd0, 8'h00);
   endtask

   task automatic test_random(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
         pending_items.push_back(random_item());
         while (pending_items.size() != 0) @(posedge clock);
      end
      no_idle = 1'b0;
   endtask

   // receiver holds off while the sender keeps offering items
   task automatic test_backpressure();
      fork
         begin
            @(posedge clock);
            hold_rsp <= 1'b1;
            repeat (400) @(posedge clock);
            hold_rsp <= 1'b0;
         end
         test_random(30);
      join
      wait_drained();
   endtask

   initial begin
      model_reset();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(400);
      write_csr(CSR_NS, 20'hFFFFF);
      write_csr(CSR_CH1, 20'd0);
      test_random(300);
      write_csr(CSR_NS, 20'h00000);
      write_csr(CSR_CH1, 20'd1);
      test_random(150);
      write_csr(CSR_NS, 20'($urandom_range(0, 20'hFFFFF)));
      write_csr(CSR_CH1, 20'($urandom_range(0, 1)));
      test_random(400);
      test_backpressure();
      write_csr(CSR_NS, 20'd22676);
      test_random(50);
      wait_drained();
      repeat (50) @(posedge clock);
      $display("covered %0d responses, %0d of them samples, over five config settings",
               results_seen, samples_seen);
      $display("including a long response hold-off and drained pauses");
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
